@@ hdl/sha1ci_pkg.sv @@
`default_nettype none

package sha1ci_pkg;

	// opcodes
	localparam logic [2:0] OP_CHOOSE = 3'd0;
	localparam logic [2:0] OP_PARITY = 3'd1;
	localparam logic [2:0] OP_MAJ    = 3'd2;
	localparam logic [2:0] OP_ROT    = 3'd3;
	localparam logic [2:0] OP_SCHED0 = 3'd4;
	localparam logic [2:0] OP_SCHED1 = 3'd5;
	// unassigned; both return zero
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int unsigned LaneW  = 32;
	localparam int unsigned NLanes = 4;

	typedef logic [LaneW-1:0] lane_t;
	typedef logic [NLanes-1:0][LaneW-1:0] vec_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] src1_lo;
		logic [63:0] src1_hi;
		logic [63:0] src2_lo;
		logic [63:0] src2_hi;
		logic [63:0] src3_lo;
		logic [63:0] src3_hi;
	} req_t;

	typedef struct packed {
		logic [63:0] result_lo;
		logic [63:0] result_hi;
	} rsp_t;

	// Working state carried down the round pipe. For non-round opcodes
	// abcd already holds the final result and the rounds pass it through.
	typedef struct packed {
		logic [2:0] opcode;
		vec_t       abcd;
		lane_t      e;
		vec_t       wk;
	} stage_t;

	function automatic lane_t rol32(input lane_t x, input int unsigned n);
		rol32 = (x << n) | (x >> (LaneW - n));
	endfunction

	function automatic lane_t round_fn(input logic [2:0] op, input lane_t x,
			input lane_t y, input lane_t z);
		unique case (op)
			OP_CHOOSE: round_fn = ((y ^ z) & x) ^ z;
			OP_PARITY: round_fn = x ^ y ^ z;
			default:   round_fn = (x & y) | ((x | y) & z);
		endcase
	endfunction

endpackage

`default_nettype wire

@@ hdl/sha1ci_prep.sv @@
`default_nettype none

// Operand decode; non-round opcodes are finished here.
module sha1ci_prep (
	input  wire sha1ci_pkg::req_t   req,
	output sha1ci_pkg::stage_t      stage
);

	sha1ci_pkg::vec_t  s1, s2, s3, t;
	sha1ci_pkg::lane_t h;

	assign s1 = {req.src1_hi, req.src1_lo};
	assign s2 = {req.src2_hi, req.src2_lo};
	assign s3 = {req.src3_hi, req.src3_lo};
	assign h  = sha1ci_pkg::rol32(s2[0], 30);

	// schedule step 1: T = op1 ^ (op2 >> 32)
	assign t = s1 ^ {32'd0, s2[3], s2[2], s2[1]};

	always_comb begin
		stage.opcode = req.opcode;
		stage.abcd   = '0;
		stage.e      = s2[0];
		stage.wk     = s3;
		unique case (req.opcode) inside
			sha1ci_pkg::OP_CHOOSE, sha1ci_pkg::OP_PARITY, sha1ci_pkg::OP_MAJ: begin
				stage.abcd = s1;
			end
			sha1ci_pkg::OP_ROT: begin
				stage.abcd = {h, h, h, h};
			end
			sha1ci_pkg::OP_SCHED0: begin
				stage.abcd = {req.src2_lo ^ req.src1_hi ^ req.src3_hi,
					req.src1_hi ^ req.src1_lo ^ req.src3_lo};
			end
			sha1ci_pkg::OP_SCHED1: begin
				stage.abcd[0] = sha1ci_pkg::rol32(t[0], 1);
				stage.abcd[1] = sha1ci_pkg::rol32(t[1], 1);
				stage.abcd[2] = sha1ci_pkg::rol32(t[2], 1);
				stage.abcd[3] = sha1ci_pkg::rol32(t[3], 1) ^ sha1ci_pkg::rol32(t[0], 2);
			end
			default: begin
				stage.abcd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/sha1ci_round.sv @@
`default_nettype none

// One SHA-1 round; consumes wk lane 0 and shifts the rest down. Non-round opcodes pass through unchanged.
module sha1ci_round (
	input  wire sha1ci_pkg::stage_t cur,
	output sha1ci_pkg::stage_t      nxt
);

	sha1ci_pkg::lane_t t;
	logic              is_round;

	assign is_round = (cur.opcode == sha1ci_pkg::OP_CHOOSE)
		|| (cur.opcode == sha1ci_pkg::OP_PARITY)
		|| (cur.opcode == sha1ci_pkg::OP_MAJ);

	assign t = sha1ci_pkg::rol32(cur.abcd[0], 5)
		+ sha1ci_pkg::round_fn(cur.opcode, cur.abcd[1], cur.abcd[2], cur.abcd[3])
		+ cur.e + cur.wk[0];

	always_comb begin
		nxt = cur;
		if (is_round) begin
			nxt.abcd[0] = t;
			nxt.abcd[1] = cur.abcd[0];
			nxt.abcd[2] = sha1ci_pkg::rol32(cur.abcd[1], 30);
			nxt.abcd[3] = cur.abcd[2];
			nxt.e       = cur.abcd[3];
			nxt.wk      = {32'd0, cur.wk[3], cur.wk[2], cur.wk[1]};
		end
	end

endmodule

`default_nettype wire

@@ hdl/sha1_crypto_instruction_unit.sv @@
// SHA-1 instruction unit: four-round hash steps (choose, parity, majority),
// fixed rotate of e, and the two message-schedule update steps.
//
// Channels: req carries one instruction (opcode plus three 128-bit operands,
// lane 0 in the low bits); rsp returns one 128-bit result per instruction.
// A transfer happens on a rising edge with valid high and stall low.
//
// Pipeline: four register stages, stage_s1 to stage_s4, the last one the
// output; round 0 runs ahead of stage_s1 and one round runs after each of
// stage_s1, stage_s2 and stage_s3.
// Throughput: one instruction per cycle while req_stall is low, any opcode mix.
//
// Stall: the four stages advance together; while rsp is held off with a
// result waiting, req_stall goes high and every stage holds. Empty slots
// do not stall the pipe.
//
// Reset: arst_n clears all stage valid bits; the pipe starts empty and
// ready. There is no state kept between instructions.
`default_nettype none

module sha1_crypto_instruction_unit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    req_valid,
	output logic                   req_stall,
	input  wire sha1ci_pkg::req_t  req,
	output logic                   rsp_valid,
	input  wire                    rsp_stall,
	output sha1ci_pkg::rsp_t       rsp
);

	sha1ci_pkg::stage_t st_0, rnd_0, rnd_1, rnd_2, rnd_3;
	sha1ci_pkg::stage_t stage_s1, stage_s2, stage_s3, stage_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv;

	// whole pipe moves unless a finished result is being held off
	assign adv       = !(valid_s4 && rsp_stall);
	assign req_stall = !adv;

	sha1ci_prep u_prep (.req(req), .stage(st_0));

	// round 0 runs in front of the first register
	sha1ci_round u_rnd0 (.cur(st_0),     .nxt(rnd_0));
	sha1ci_round u_rnd1 (.cur(stage_s1), .nxt(rnd_1));
	sha1ci_round u_rnd2 (.cur(stage_s2), .nxt(rnd_2));
	sha1ci_round u_rnd3 (.cur(stage_s3), .nxt(rnd_3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s1 <= rnd_0;
			stage_s2 <= rnd_1;
			stage_s3 <= rnd_2;
			stage_s4 <= rnd_3;
		end
	end

	assign rsp_valid     = valid_s4;
	assign rsp.result_lo = {stage_s4.abcd[1], stage_s4.abcd[0]};
	assign rsp.result_hi = {stage_s4.abcd[3], stage_s4.abcd[2]};

	// an item in stage 2 moves on to stage 3 with its opcode intact
	a_s2_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && adv |=> valid_s3 && stage_s3.opcode == $past(stage_s2.opcode))
		else $error("stage 2 item lost or corrupted");

	// a held result keeps the pipe frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && rsp_stall |=> valid_s4 && $stable(stage_s4))
		else $error("held result changed");

	// unused opcodes return zero
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && (stage_s4.opcode == sha1ci_pkg::OP_SPARE6
			|| stage_s4.opcode == sha1ci_pkg::OP_SPARE7)
		|-> rsp.result_lo == 64'd0 && rsp.result_hi == 64'd0)
		else $error("unused opcode gave nonzero result");

	// fixed rotate fills all four lanes with the same word
	a_rot_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && stage_s4.opcode == sha1ci_pkg::OP_ROT
		|-> rsp.result_lo == rsp.result_hi
			&& rsp.result_lo[63:32] == rsp.result_lo[31:0])
		else $error("rotate lanes differ");

endmodule

`default_nettype wire
